// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the extended gcd block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EGCD_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define EGCD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== rtl/egcd_pkg.sv =====
// Types, constants and command structs shared by the extended gcd block.
`default_nettype none

package egcd_pkg;

  localparam int FIELD_W           = 32;
  localparam int OUT_W             = 31;
  localparam int OPERAND_WIDTH_DEF = 32;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  typedef struct packed {
    logic                      mode;
    logic signed [FIELD_W-1:0] operand_a;
    logic signed [FIELD_W-1:0] operand_b;
  } in_beat_t;

  typedef struct packed {
    logic        [OUT_W-1:0]   divisor;
    logic signed [FIELD_W-1:0] coef_x;
    logic signed [FIELD_W-1:0] coef_y;
    logic        [OUT_W-1:0]   inverse;
    logic                      has_inverse;
  } out_beat_t;

  typedef enum logic [1:0] {
    DIV_STEP    = 2'd0,
    DIV_REDUCE  = 2'd1,
    DIV_INVERSE = 2'd2
  } div_src_e;

  typedef struct packed {
    logic     load_in;
    logic     div_start;
    div_src_e div_src;
    logic     reduce;
    logic     init;
    logic     mul;
    logic     update;
    logic     load_out;
  } egcd_cmd_t;

  typedef struct packed {
    logic mode;
    logic mod_bad;
    logic r1_zero;
    logic gcd_one;
    logic div_done;
  } egcd_status_t;

endpackage

`default_nettype wire

// ===== rtl/egcd_stream_if.sv =====
// Valid/ready stream interface that carries one beat of payload.
`default_nettype none

interface egcd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/extended_gcd_mod_inverse.sv =====
// Top level of the extended gcd and modular inverse block.
// Each input beat carries a mode and two signed operands and yields exactly one result beat.
// Mode 0 returns the gcd of the operand magnitudes with Bezout coefficients signed to match
// the operands; mode 1 reduces the first operand by the positive modulus, then returns the
// gcd, the coefficients and, when the gcd is one, the non-negative inverse. One item is in
// flight at a time. The effective operand width is OPERAND_WIDTH, capped at 32. Each quotient
// step, the modulus reduction and the final inverse fold each use one pass of the restoring
// divider, which retires one quotient bit per cycle. A mode 1 item whose modulus is not
// positive returns an all-zero result beat. A result beat sits in an output register, so the
// next input beat is taken while the previous result waits.
`default_nettype none

module extended_gcd_mod_inverse #(
  parameter int OPERAND_WIDTH = egcd_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  egcd_stream_if.sink          in_i,
  egcd_stream_if.source        out_o
);

  egcd_pkg::egcd_cmd_t    cmd;
  egcd_pkg::egcd_status_t status;
  egcd_pkg::out_beat_t    out_beat;
  logic                   in_ready;
  logic                   out_valid;

  egcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .out_valid_o(out_valid),
    .out_ready_i(out_o.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  egcd_datapath #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_beat_i (in_i.payload),
    .cmd_i     (cmd),
    .status_o  (status),
    .out_beat_o(out_beat)
  );

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid;
  assign out_o.payload = out_beat;

endmodule

`default_nettype wire

// ===== rtl/egcd_div.sv =====
// Restoring unsigned divider that retires one quotient bit per cycle.
`default_nettype none

module egcd_div #(
  parameter int WIDTH = egcd_pkg::FIELD_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic [WIDTH-1:0] quotient_o,
  output logic [WIDTH-1:0] remainder_o,
  output logic             done_o
);

  localparam int CNTW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] dvs_q;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;

  assign shifted = {acc_q, quo_q[WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    acc_d  = acc_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = CNTW'(WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[WIDTH]) begin
        acc_d = diff[WIDTH-1:0];
        quo_d = {quo_q[WIDTH-2:0], 1'b1};
      end else begin
        acc_d = shifted[WIDTH-1:0];
        quo_d = {quo_q[WIDTH-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign quotient_o  = quo_q;
  assign remainder_o = acc_q;
  assign done_o      = done_q;

endmodule

`default_nettype wire

// ===== rtl/egcd_datapath.sv =====
// Operand, remainder and coefficient registers with the shared divider and result stage.
`default_nettype none

module egcd_datapath #(
  parameter int OPERAND_WIDTH = egcd_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  egcd_pkg::in_beat_t     in_beat_i,
  input  egcd_pkg::egcd_cmd_t    cmd_i,
  output egcd_pkg::egcd_status_t status_o,
  output egcd_pkg::out_beat_t    out_beat_o
);

  localparam int FW   = egcd_pkg::FIELD_W;
  localparam int OW   = egcd_pkg::OUT_W;
  localparam int EW   = (OPERAND_WIDTH > FW) ? FW : OPERAND_WIDTH;
  localparam int CW   = EW + 2;
  localparam int CMPW = CW + FW;

  logic                 mode_q;
  logic                 na_q, nb_q;
  logic [EW-1:0]        ma_q, mb_q;
  logic [EW-1:0]        r0_q, r1_q;
  logic signed [CW-1:0] s0_q, s1_q, t0_q, t1_q;
  logic signed [CW-1:0] ps_q, pt_q;
  egcd_pkg::out_beat_t  out_q, out_d;

  logic [EW-1:0]        a_raw, b_raw, a_mag, b_mag;
  logic                 a_neg, b_neg;
  logic [EW-1:0]        dvd, dvs, quo, rem;
  logic                 div_done;
  logic signed [CW-1:0] q_ext;
  logic                 a_gt;
  logic                 x_sign, y_sign, x_neg, y_neg;
  logic [CW-1:0]        x_mag, y_mag;
  logic [EW-1:0]        inv_w;
  logic [CMPW-1:0]      g_ext;
  logic                 mod_bad, gcd_one;

  function automatic logic [FW-1:0] enc_coef(input logic neg, input logic [CW-1:0] mag);
    logic [CMPW-1:0] m_ext;
    logic [CMPW-1:0] lim;
    logic [FW-1:0]   val;
    m_ext = CMPW'(mag);
    lim   = CMPW'(egcd_pkg::OUT_MAX);
    if (m_ext > lim) begin
      m_ext = lim;
    end
    val = m_ext[FW-1:0];
    return neg ? (FW'(0) - val) : val;
  endfunction

  assign a_raw = in_beat_i.operand_a[EW-1:0];
  assign b_raw = in_beat_i.operand_b[EW-1:0];
  assign a_neg = a_raw[EW-1];
  assign b_neg = b_raw[EW-1];
  assign a_mag = a_neg ? (~a_raw + EW'(1)) : a_raw;
  assign b_mag = b_neg ? (~b_raw + EW'(1)) : b_raw;

  assign x_sign = s0_q[CW-1];
  assign y_sign = t0_q[CW-1];
  assign x_mag  = x_sign ? (~unsigned'(s0_q) + CW'(1)) : unsigned'(s0_q);
  assign y_mag  = y_sign ? (~unsigned'(t0_q) + CW'(1)) : unsigned'(t0_q);
  assign x_neg  = (x_sign ^ na_q) && (x_mag != '0);
  assign y_neg  = (y_sign ^ nb_q) && (y_mag != '0);

  always_comb begin
    case (cmd_i.div_src)
      egcd_pkg::DIV_REDUCE: begin
        dvd = ma_q;
        dvs = mb_q;
      end
      egcd_pkg::DIV_INVERSE: begin
        dvd = x_mag[EW-1:0];
        dvs = mb_q;
      end
      egcd_pkg::DIV_STEP: begin
        dvd = r0_q;
        dvs = r1_q;
      end
      default: begin
        dvd = r0_q;
        dvs = r1_q;
      end
    endcase
  end

  egcd_div #(
    .WIDTH(EW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .quotient_o (quo),
    .remainder_o(rem),
    .done_o     (div_done)
  );

  assign q_ext = signed'({2'b00, quo});
  assign a_gt  = ma_q > mb_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q <= in_beat_i.mode;
      na_q   <= a_neg;
      nb_q   <= b_neg;
      ma_q   <= a_mag;
      mb_q   <= b_mag;
    end
    if (cmd_i.reduce) begin
      ma_q <= rem;
      if (rem == '0) begin
        na_q <= 1'b0;
      end
    end
    if (cmd_i.init) begin
      r0_q <= a_gt ? ma_q : mb_q;
      r1_q <= a_gt ? mb_q : ma_q;
      s0_q <= a_gt ? CW'(1) : CW'(0);
      s1_q <= a_gt ? CW'(0) : CW'(1);
      t0_q <= a_gt ? CW'(0) : CW'(1);
      t1_q <= a_gt ? CW'(1) : CW'(0);
    end
    if (cmd_i.mul) begin
      ps_q <= q_ext * s1_q;
      pt_q <= q_ext * t1_q;
    end
    if (cmd_i.update) begin
      r0_q <= r1_q;
      r1_q <= rem;
      s0_q <= s1_q;
      s1_q <= s0_q - ps_q;
      t0_q <= t1_q;
      t1_q <= t0_q - pt_q;
    end
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign mod_bad = nb_q || (mb_q == '0);
  assign gcd_one = (r0_q == EW'(1));
  assign inv_w   = (x_neg && (rem != '0)) ? (mb_q - rem) : rem;
  assign g_ext   = CMPW'(r0_q);

  always_comb begin
    out_d = '0;
    if (!(mode_q && mod_bad)) begin
      out_d.divisor = (g_ext > CMPW'(egcd_pkg::OUT_MAX)) ? egcd_pkg::OUT_MAX
                                                          : g_ext[OW-1:0];
      out_d.coef_x  = signed'(enc_coef(x_neg, x_mag));
      out_d.coef_y  = signed'(enc_coef(y_neg, y_mag));
      if (mode_q && gcd_one) begin
        out_d.inverse     = OW'(inv_w);
        out_d.has_inverse = 1'b1;
      end
    end
  end

  assign status_o.mode     = mode_q;
  assign status_o.mod_bad  = mod_bad;
  assign status_o.r1_zero  = (r1_q == '0);
  assign status_o.gcd_one  = gcd_one;
  assign status_o.div_done = div_done;
  assign out_beat_o        = out_q;

endmodule

`default_nettype wire

// ===== rtl/egcd_ctrl.sv =====
// Controller state machine that sequences the reduction, quotient steps, inverse fold and result beat.
`default_nettype none

module egcd_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  egcd_pkg::egcd_status_t status_i,
  output egcd_pkg::egcd_cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_DISPATCH = 9'b000000010,
    ST_REDUCE   = 9'b000000100,
    ST_INIT     = 9'b000001000,
    ST_TEST     = 9'b000010000,
    ST_DIVIDE   = 9'b000100000,
    ST_UPDATE   = 9'b001000000,
    ST_INVMOD   = 9'b010000000,
    ST_FINISH   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (!status_i.mode) begin
          state_d = ST_INIT;
        end else if (status_i.mod_bad) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = egcd_pkg::DIV_REDUCE;
          state_d         = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (status_i.div_done) begin
          cmd_o.reduce = 1'b1;
          state_d      = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = ST_TEST;
      end
      ST_TEST: begin
        if (!status_i.r1_zero) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = egcd_pkg::DIV_STEP;
          state_d         = ST_DIVIDE;
        end else if (status_i.mode && status_i.gcd_one) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = egcd_pkg::DIV_INVERSE;
          state_d         = ST_INVMOD;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_DIVIDE: begin
        if (status_i.div_done) begin
          cmd_o.mul = 1'b1;
          state_d   = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_TEST;
      end
      ST_INVMOD: begin
        if (status_i.div_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/egcd_checker.sv =====
// Port-level checker for the extended gcd block and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module egcd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input egcd_pkg::out_beat_t out_payload_i
);

  // Only one item is in flight, so an accepted beat closes the input side.
  `EGCD_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // A stalled result beat stays valid and unchanged.
  `EGCD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_payload_i))

  // A result never appears in the cycle right after an input beat is taken.
  `EGCD_ASSERT_IMPLY(a_no_early_result, clk_i, rst_ni, $rose(out_valid_i), !$past(in_valid_i && in_ready_i))

endmodule

bind extended_gcd_mod_inverse egcd_checker u_egcd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_payload_i(out_o.payload)
);

`default_nettype wire
